@@ sv/lod_pkg.sv @@
`timescale 1ns / 1ps
// lod_pkg: shared constants for the loud onset detector
package lod_pkg;

	// configuration register map
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [0:0]  REG_LOUD_THRESHOLD = 1'b0;

	// fixed field widths
	localparam int unsigned THR_W       = 16;
	localparam int unsigned IDX_W       = 32;
	localparam int unsigned MAG_OUT_W   = 16;

	localparam logic [THR_W-1:0] THR_RESET = 16'd8192;

endpackage

@@ sv/lod_sample_if.sv @@
`timescale 1ns / 1ps
// lod_sample_if: input item channel carrying one audio sample
interface lod_sample_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

@@ sv/lod_onset_if.sv @@
`timescale 1ns / 1ps
// lod_onset_if: result item channel carrying one onset report
interface lod_onset_if
	import lod_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [IDX_W-1:0]     onset_index;
	logic [MAG_OUT_W-1:0] magnitude;

	modport source (output valid, output onset_index, output magnitude, input ready);
	modport sink   (input valid, input onset_index, input magnitude, output ready);
endinterface

@@ sv/loud_onset_detector_core.sv @@
`timescale 1ns / 1ps
// loud_onset_detector_core: running-mean threshold onset detector, top level
//
// One signed audio sample enters per item and at most one onset item leaves.
// The stream is split into windows of SEGMENT_LEN/2 samples; each segment of
// SEGMENT_LEN samples starts its running mean of absolute values from the sum
// of the window before it. A sample is loud when |mag - mean| exceeds
// loud_threshold, tested exactly as |mag*count - sum| > loud_threshold*count.
// Quiet samples feed the mean and clear the loud flag; the first loud sample
// after a quiet one reports its absolute index (first sample after reset is
// index 0, wrapping at 2^32) and its magnitude. After reset the block acts as
// if a full segment of quiet zero samples came before sample 0.
// Throughput is one sample per clock while the result register is free or
// draining: a sample is captured in an input register, and the mean update
// (two multiplies, a subtract and a compare) runs combinationally as it moves
// into the state and result registers. An onset item is presented once its
// sample has passed the input register and then the result register. A
// full result register only holds the pipe when its item is not being taken.
// loud_threshold lives at byte address 0 of the APB port and should only be
// written while the block is idle.
module loud_onset_detector_core
	import lod_pkg::*;
#(
	parameter int SEGMENT_LEN = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,

	lod_sample_if.sink            samples,
	lod_onset_if.source           onsets,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// derived sizes
	localparam int HALF_LEN = SEGMENT_LEN / 2;
	localparam int PH_W     = $clog2(SEGMENT_LEN);
	localparam int CNT_W    = $clog2(SEGMENT_LEN + HALF_LEN + 1);
	localparam int SUM_W    = $clog2(SEGMENT_LEN + HALF_LEN + 1) + SAMPLE_BITS;
	localparam int SEED_W   = $clog2(HALF_LEN + 1) + SAMPLE_BITS;
	localparam int PROD_W   = SAMPLE_BITS + CNT_W;
	localparam int THP_W    = THR_W + CNT_W;
	localparam int DW0      = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int DW       = ((DW0 > THP_W) ? DW0 : THP_W) + 1;
	localparam int MW       = (SAMPLE_BITS > MAG_OUT_W) ? SAMPLE_BITS : MAG_OUT_W;

	// configuration
	logic [THR_W-1:0] loud_threshold_q;

	// input register
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;

	// detector state
	logic [SUM_W-1:0]  segment_sum_q;
	logic [CNT_W-1:0]  segment_count_q;
	logic [SEED_W-1:0] seed_sum_q;
	logic              loud_flag_q;
	logic [PH_W-1:0]   segment_phase_q;
	logic [IDX_W-1:0]  sample_counter_q;

	// result register
	logic                 onset_valid_q;
	logic [IDX_W-1:0]     onset_index_q;
	logic [MAG_OUT_W-1:0] magnitude_q;

	// datapath
	logic                   proc;
	logic                   seg_start;
	logic [SAMPLE_BITS-1:0] mag;
	logic [MW-1:0]          mag_wide;
	logic [SUM_W-1:0]       sum_e;
	logic [CNT_W-1:0]       cnt_e;
	logic [SEED_W-1:0]      seed_e;
	logic [PROD_W-1:0]      prod;
	logic [THP_W-1:0]       thr_prod;
	logic [DW-1:0]          diff;
	logic [DW-1:0]          abs_diff;
	logic                   loud;
	logic                   onset;

	// apb: single register, no wait states
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LOUD_THRESHOLD)
		? {{(APB_DATA_W-THR_W){1'b0}}, loud_threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loud_threshold_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_LOUD_THRESHOLD) begin
			loud_threshold_q <= pwdata[THR_W-1:0];
		end
	end

	// the captured sample moves on whenever the result slot is free or draining
	assign proc          = valid_s1 && (!onset_valid_q || onsets.ready);
	assign samples.ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_s1 <= samples.sample;
		end
	end

	// absolute value; the most negative code maps to 2^(SAMPLE_BITS-1)
	assign mag      = sample_s1[SAMPLE_BITS-1] ? (~sample_s1 + 1'b1) : sample_s1;
	assign mag_wide = MW'(mag);

	// a new segment takes the previous window as its seed
	assign seg_start = (segment_phase_q == '0);
	assign sum_e     = seg_start ? SUM_W'(seed_sum_q) : segment_sum_q;
	assign cnt_e     = seg_start ? CNT_W'(HALF_LEN) : segment_count_q;
	assign seed_e    = seg_start ? '0 : seed_sum_q;

	// exact test |mag*count - sum| > threshold*count
	assign prod     = PROD_W'(mag) * PROD_W'(cnt_e);
	assign thr_prod = THP_W'(loud_threshold_q) * THP_W'(cnt_e);
	assign diff     = DW'(prod) - DW'(sum_e);
	assign abs_diff = diff[DW-1] ? (~diff + 1'b1) : diff;
	assign loud     = abs_diff > DW'(thr_prod);
	assign onset    = loud && !loud_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_sum_q    <= '0;
			segment_count_q  <= CNT_W'(SEGMENT_LEN);
			seed_sum_q       <= '0;
			loud_flag_q      <= 1'b0;
			segment_phase_q  <= PH_W'(HALF_LEN);
			sample_counter_q <= '0;
		end else if (proc) begin
			// loud samples stay out of the mean
			if (loud) begin
				segment_sum_q   <= sum_e;
				segment_count_q <= cnt_e;
			end else begin
				segment_sum_q   <= sum_e + SUM_W'(mag);
				segment_count_q <= cnt_e + 1'b1;
			end
			// second half of every segment builds the next seed
			if (segment_phase_q >= PH_W'(HALF_LEN)) begin
				seed_sum_q <= seed_e + SEED_W'(mag);
			end else begin
				seed_sum_q <= seed_e;
			end
			loud_flag_q <= loud;
			if (segment_phase_q == PH_W'(SEGMENT_LEN - 1)) begin
				segment_phase_q <= '0;
			end else begin
				segment_phase_q <= segment_phase_q + 1'b1;
			end
			sample_counter_q <= sample_counter_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			onset_valid_q <= 1'b0;
		end else if (proc && onset) begin
			onset_valid_q <= 1'b1;
		end else if (onsets.ready) begin
			onset_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && onset) begin
			onset_index_q <= sample_counter_q;
			magnitude_q   <= mag_wide[MAG_OUT_W-1:0];
		end
	end

	assign onsets.valid       = onset_valid_q;
	assign onsets.onset_index = onset_index_q;
	assign onsets.magnitude   = magnitude_q;

`ifndef SYNTHESIS
	// the running count never drops below a seeded window
	a_count_floor: assert property (@(posedge clk) disable iff (!arst_n)
		segment_count_q >= CNT_W'(HALF_LEN))
		else $error("segment count below half segment");

	// phase stays inside the segment
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		segment_phase_q <= PH_W'(SEGMENT_LEN - 1))
		else $error("segment phase out of range");

	// the input register is never overwritten while it holds an unprocessed item
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && valid_s1) |-> proc)
		else $error("input register overrun");

	// every processed sample advances the index by one
	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> (sample_counter_q == $past(sample_counter_q) + 1'b1))
		else $error("sample counter did not advance");

	// a fresh onset item comes only from a processed loud sample
	a_onset_source: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && onset) |=> (onset_valid_q && loud_flag_q))
		else $error("onset not registered with loud flag");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the loud onset detector core
module tb_top;
	import lod_pkg::*;

	// block configuration under test
	localparam int SEG_LEN  = 1024;
	localparam int HALF_SEG = SEG_LEN / 2;
	localparam int SMP_W    = 16;

	// register map: register index i sits at byte address 4*i
	localparam int unsigned UNUSED_REG_IDX = 1;
	localparam logic [APB_ADDR_W-1:0] THR_ADDR    = APB_ADDR_W'(REG_LOUD_THRESHOLD) << 2;
	localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR = APB_ADDR_W'(UNUSED_REG_IDX) << 2;

	// cycles to let pass after the last onset before touching configuration
	localparam int SETTLE_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 325;

	typedef struct packed {
		logic [IDX_W-1:0]     onset_index;
		logic [MAG_OUT_W-1:0] magnitude;
	} onset_t;

	logic clk;
	logic arst_n;

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lod_sample_if #(.SAMPLE_BITS(SMP_W)) samples_ch ();
	lod_onset_if                         onsets_ch ();

	loud_onset_detector_core #(
		.SEGMENT_LEN (SEG_LEN),
		.SAMPLE_BITS (SMP_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.onsets  (onsets_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// onsets predicted from accepted samples, oldest first
	onset_t pending_onsets[$];

	// bookkeeping
	int mismatch_count;
	int samples_sent;
	int onsets_seen;
	int thr_settings;

	// idle rates in percent for the sample sender and the onset receiver
	int tx_idle_pct;
	int rx_idle_pct;

	// mirror of the detector state, updated once per accepted sample
	logic [THR_W-1:0] loud_thr;
	longint           seg_sum;
	longint           seg_cnt;
	longint           seed_sum;
	bit               loud_now;
	int               seg_phase;
	logic [IDX_W-1:0] sample_idx;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#5_000_000;
		$display("FAIL loud_onset_detector_core");
		$finish;
	end

	task automatic report_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("error at %0t: %s", $realtime, msg);
	endtask

	// advance the mirrored state by one sample, return 1 when it is an onset
	function automatic bit detect_onset(input logic [SMP_W-1:0] smp, output onset_t res);
		longint mag;
		longint diff;
		longint abs_diff;
		bit     is_loud;
		bit     fired;
		mag   = ($signed(smp) < 0) ? -longint'($signed(smp)) : longint'($signed(smp));
		fired = 1'b0;
		res   = '0;
		// a new segment starts from the window just finished
		if (seg_phase == 0) begin
			seg_sum  = seed_sum;
			seg_cnt  = HALF_SEG;
			seed_sum = 0;
		end
		// exact test of |mag - mean| > thr with the count multiplied through
		diff     = mag * seg_cnt - seg_sum;
		abs_diff = (diff < 0) ? -diff : diff;
		is_loud  = abs_diff > longint'(loud_thr) * seg_cnt;
		if (is_loud) begin
			// only the first loud sample of a stretch reports
			if (!loud_now) begin
				loud_now        = 1'b1;
				res.onset_index = sample_idx;
				res.magnitude   = mag[MAG_OUT_W-1:0];
				fired           = 1'b1;
			end
		end else begin
			// quiet samples feed the running mean
			loud_now = 1'b0;
			seg_sum += mag;
			seg_cnt += 1;
		end
		// the second window of each segment seeds the next one, loud or not
		if (seg_phase >= HALF_SEG)
			seed_sum += mag;
		seg_phase = (seg_phase + 1 >= SEG_LEN) ? 0 : seg_phase + 1;
		sample_idx++;
		return fired;
	endfunction

	// onset receiver: random stalls, every taken item checked against the oldest prediction
	always @(posedge clk) begin
		onset_t want;
		if (!arst_n) begin
			onsets_ch.ready <= 1'b0;
		end else begin
			onsets_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			if (onsets_ch.valid && onsets_ch.ready) begin
				onsets_seen++;
				if (pending_onsets.size() == 0) begin
					report_error($sformatf("unexpected onset index %0d magnitude %0d",
						onsets_ch.onset_index, onsets_ch.magnitude));
				end else begin
					want = pending_onsets.pop_front();
					if (onsets_ch.onset_index !== want.onset_index)
						report_error($sformatf("onset_index expected %0d got %0d",
							want.onset_index, onsets_ch.onset_index));
					if (onsets_ch.magnitude !== want.magnitude)
						report_error($sformatf("magnitude expected %0d got %0d (index %0d)",
							want.magnitude, onsets_ch.magnitude, want.onset_index));
				end
			end
		end
	end

	// send one sample with a random lead-in gap, predict once it is taken
	task automatic send_sample(input logic [SMP_W-1:0] smp);
		onset_t res;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= smp;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		samples_sent++;
		if (detect_onset(smp, res))
			pending_onsets.push_back(res);
	endtask

	// stop sending, wait for every predicted onset, then let the pipe settle
	task automatic drain_onsets();
		samples_ch.valid <= 1'b0;
		while (pending_onsets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// writes to anything but the threshold are dropped
		if (addr == THR_ADDR)
			loud_thr = data[THR_W-1:0];
	endtask

	task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr,
		input logic [APB_DATA_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			report_error($sformatf("register read at %0d expected %0d got %0d",
				addr, want, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] thr);
		drain_onsets();
		apb_write(THR_ADDR, APB_DATA_W'(thr));
		apb_read_check(THR_ADDR, APB_DATA_W'(thr));
		thr_settings++;
	endtask

	// turn a magnitude into a sample of random sign, 32768 only fits as negative
	function automatic logic [SMP_W-1:0] mag_to_sample(input int mag);
		logic [SMP_W-1:0] s;
		s = SMP_W'(mag);
		if (mag == 32768 || $urandom_range(0, 1))
			s = -s;
		return s;
	endfunction

	// threshold register comes out of reset at its documented value
	task automatic test_reset_state();
		apb_read_check(THR_ADDR, APB_DATA_W'(THR_RESET));
		thr_settings++;
	endtask

	// field extremes and the loud/quiet transitions at the reset threshold
	task automatic test_directed_extremes();
		send_sample(16'sd0);
		send_sample(16'sd8192);     // right on the threshold: still quiet
		send_sample(16'sd32767);    // loud after quiet: onset
		send_sample(-16'sd32768);   // loud while loud: nothing
		send_sample(-16'sd1);       // quiet again
		send_sample(-16'sd32768);   // onset with the largest magnitude
		send_sample(16'sd1);
		send_sample(16'sd8193);     // one above the threshold value, still quiet against the mean
		send_sample(16'sd32767);
		send_sample(16'sd0);
		send_sample(-16'sd8193);
	endtask

	// a write to an index other than the threshold must leave it alone
	task automatic test_unused_register();
		drain_onsets();
		apb_write(UNUSED_ADDR, 32'h0000_1234);
		apb_read_check(THR_ADDR, APB_DATA_W'(loud_thr));
	endtask

	// smallest and largest thresholds
	task automatic test_threshold_extremes();
		set_threshold(16'd0);
		send_sample(16'sd0);
		send_sample(16'sd5);        // any departure from the mean is loud
		send_sample(16'sd5);
		send_sample(-16'sd32768);
		send_sample(16'sd0);
		set_threshold(16'd32768);
		send_sample(-16'sd32768);   // nothing can be loud at this threshold
		send_sample(16'sd32767);
		send_sample(16'sd0);
		send_sample(16'sd12000);
	endtask

	// quiet noise around a level, loud bursts of a few samples, some raw values
	task automatic test_random_traffic(input int tx_pct, input int rx_pct,
		input logic [THR_W-1:0] thr, input int n_items);
		int base;
		int half_band;
		int mag;
		int up;
		int down;
		int burst_left;
		int r;
		logic [SMP_W-1:0] smp;
		set_threshold(thr);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		base        = $urandom_range(0, 16000);
		half_band   = int'(thr) / 2;
		burst_left  = 0;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (burst_left > 0 || (r >= 80 && r < 92)) begin
				// loud sample: push well past the threshold above or below the level
				if (burst_left > 0)
					burst_left--;
				else
					burst_left = $urandom_range(0, 4);
				up   = base + int'(thr) + 1 + $urandom_range(0, 4000);
				down = base - int'(thr) - 1 - $urandom_range(0, 4000);
				if (up <= 32768 && ($urandom_range(0, 1) || down < 0))
					mag = up;
				else if (down >= 0)
					mag = down;
				else
					mag = $urandom_range(0, 32768);
				smp = mag_to_sample(mag);
			end else if (r < 80) begin
				// quiet sample inside the band around the level
				mag = base + $urandom_range(0, 2 * half_band) - half_band;
				if (mag < 0)
					mag = 0;
				if (mag > 32767)
					mag = 32767;
				smp = mag_to_sample(mag);
			end else begin
				smp = SMP_W'($urandom_range(0, 65535));
			end
			send_sample(smp);
		end
	endtask

	initial begin
		// every input known from the start
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		samples_ch.valid  <= 1'b0;
		samples_ch.sample <= '0;

		mismatch_count = 0;
		samples_sent   = 0;
		onsets_seen    = 0;
		thr_settings   = 0;
		tx_idle_pct    = 36;
		rx_idle_pct    = 88;

		// detector state after reset: as if a quiet segment of zeros came first
		loud_thr   = THR_RESET;
		seg_sum    = 0;
		seg_cnt    = SEG_LEN;
		seed_sum   = 0;
		loud_now   = 1'b0;
		seg_phase  = HALF_SEG;
		sample_idx = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_extremes();
		test_unused_register();
		test_threshold_extremes();

		// sender light and receiver heavy, then swapped, then no idling
		test_random_traffic(36, 88, 16'($urandom_range(1000, 12000)), ITEMS_PER_PHASE);
		test_random_traffic(36, 88, 16'd0, ITEMS_PER_PHASE);
		test_random_traffic(88, 36, 16'($urandom_range(0, 32768)), ITEMS_PER_PHASE);
		test_random_traffic(88, 36, 16'd32768, ITEMS_PER_PHASE);
		test_random_traffic(0, 0, 16'($urandom_range(2000, 6000)), ITEMS_PER_PHASE);
		test_random_traffic(0, 0, 16'($urandom_range(0, 32768)), ITEMS_PER_PHASE);

		drain_onsets();
		repeat (10) @(posedge clk);
		if (pending_onsets.size() != 0)
			report_error($sformatf("%0d onsets never arrived", pending_onsets.size()));

		$display("checked %0d onsets from %0d samples across %0d threshold settings",
			onsets_seen, samples_sent, thr_settings);
		$display("segments crossed: %0d, errors: %0d", samples_sent / SEG_LEN, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS loud_onset_detector_core");
		end else begin
			$display("FAIL loud_onset_detector_core");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lod_pkg.sv
sv/lod_sample_if.sv
sv/lod_onset_if.sv
sv/loud_onset_detector_core.sv
verif/tb_top.sv
